// ===== rtl/nas_pkg.sv =====
// Shared types and constants for the neighbor average stencil core.
// Holds the tile limits, register indexes, divisor codes and the queue item.
// No dependencies.
package nas_pkg;

  localparam int MAX_TILE   = 256;
  localparam int LINE_DEPTH = MAX_TILE + 2;
  localparam int CNT_W      = $clog2(LINE_DEPTH);

  localparam int DATA_W     = 32;
  localparam int SUM_W      = DATA_W + 2;
  localparam int TILE_W     = 9;
  localparam int CFG_IDX_W  = 3;

  localparam logic [TILE_W-1:0] TILE_RESET = 9'd256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // floor(u/3) = (u * RECIP3) >> 36 for u < 2^35
  localparam logic [34:0] RECIP3    = 35'd22906492246;
  localparam logic [16:0] RECIP3_HI = RECIP3[34:18];
  localparam logic [17:0] RECIP3_LO = RECIP3[17:0];
  // bias that makes any three-term sum non-negative
  localparam logic [SUM_W-1:0] OFFSET3 = 34'h1_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE = 3'd0,
    CFG_HAS_UP    = 3'd1,
    CFG_HAS_DOWN  = 3'd2,
    CFG_HAS_LEFT  = 3'd3,
    CFG_HAS_RIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_BY_2 = 2'd0,
    DIV_BY_3 = 2'd1,
    DIV_BY_4 = 2'd2
  } div_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [CNT_W-1:0]         wr_addr;
    logic [CNT_W-1:0]         rd_addr;
    logic                     produce;
    logic                     use_up;
    logic                     use_down;
    logic                     use_left;
    logic                     use_right;
    div_e                     div;
    logic                     last;
  } item_t;

endpackage

// ===== rtl/neighbor_average_stencil_core.sv =====
// Four-neighbor averaging stencil over a haloed square tile, one sample a cycle unless stalled.
// Path: the beat directly below a cell, once accepted, yields its result through the queue,
// the line-store read register and the sum, bias, partial-product and output registers.
// Throughput: one sample per cycle while sample_stall_o is low; a 4-entry queue absorbs output stalls.
// Reset: tile size 256, side flags clear, position zero, queue and pipe empty;
// the line store is not cleared, each row is rewritten before it is read.
module neighbor_average_stencil_core import nas_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [TILE_W-1:0]        cfg_data_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     sample_valid_i,
  output logic                     sample_stall_o,
  output logic signed [DATA_W-1:0] average_o,
  output logic                     last_o,
  output logic                     average_valid_o,
  input  logic                     average_stall_i
);

  logic  q_full;
  logic  push;
  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  pop;

  assign sample_stall_o = q_full;

  nas_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .full_i         (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  nas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (front_item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head_item),
    .head_valid_o (head_valid)
  );

  nas_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_item),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .average_o       (average_o),
    .last_o          (last_o),
    .average_valid_o (average_valid_o),
    .average_stall_i (average_stall_i)
  );

endmodule

// ===== rtl/nas_front.sv =====
// Front end: configuration registers, padded-tile position counters and
// classification of each incoming sample into a queue item.
// Depends on nas_pkg.
module nas_front import nas_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [TILE_W-1:0]        cfg_data_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     sample_valid_i,
  input  logic                     full_i,
  output logic                     push_o,
  output item_t                    item_o
);

  logic [TILE_W-1:0] tile_q;
  logic              has_up_q;
  logic              has_down_q;
  logic              has_left_q;
  logic              has_right_q;
  logic [CNT_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  t_eff;
  logic [CNT_W-1:0]  w_last;
  logic [2:0]        n_used;
  logic              tile_wr;

  assign push_o  = sample_valid_i && !full_i;
  assign tile_wr = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_TILE_SIZE);

  always_comb begin
    priority if (tile_q < TILE_W'(2)) begin
      t_eff = CNT_W'(2);
    end else if (int'(tile_q) > MAX_TILE) begin
      t_eff = CNT_W'(MAX_TILE);
    end else begin
      t_eff = CNT_W'(tile_q);
    end
  end

  assign w_last = t_eff + CNT_W'(1);

  always_comb begin
    item_o.sample    = sample_i;
    item_o.wr_addr   = col_q;
    // read one column ahead; the last column fetches column zero for the next row
    item_o.rd_addr   = (col_q == w_last) ? '0 : col_q + CNT_W'(1);
    item_o.produce   = (row_q >= CNT_W'(2)) && (col_q != '0) && (col_q <= t_eff);
    item_o.use_up    = (row_q > CNT_W'(2)) || has_up_q;
    item_o.use_down  = (row_q <= t_eff) || has_down_q;
    item_o.use_left  = (col_q > CNT_W'(1)) || has_left_q;
    item_o.use_right = (col_q < t_eff) || has_right_q;
    item_o.last      = (row_q == w_last) && (col_q == t_eff);
    n_used = {2'b00, item_o.use_up} + {2'b00, item_o.use_down}
           + {2'b00, item_o.use_left} + {2'b00, item_o.use_right};
    unique case (n_used)
      3'd4:    item_o.div = DIV_BY_4;
      3'd3:    item_o.div = DIV_BY_3;
      default: item_o.div = DIV_BY_2;
    endcase
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (tile_wr) begin
      row_d = '0;
      col_d = '0;
    end else if (push_o) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == w_last) ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q      <= TILE_RESET;
      has_up_q    <= 1'b0;
      has_down_q  <= 1'b0;
      has_left_q  <= 1'b0;
      has_right_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_TILE_SIZE: tile_q      <= cfg_data_i;
          CFG_HAS_UP:    has_up_q    <= cfg_data_i[0];
          CFG_HAS_DOWN:  has_down_q  <= cfg_data_i[0];
          CFG_HAS_LEFT:  has_left_q  <= cfg_data_i[0];
          CFG_HAS_RIGHT: has_right_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/nas_queue.sv =====
// Short FIFO of classified items between the front end and the datapath.
// Depends on nas_pkg.
module nas_queue import nas_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t head_o,
  output logic  head_valid_o
);

  item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/nas_back.sv =====
// Datapath: line store, neighbor gather and sum, floored divide by 2 or 4 by shift
// and by 3 through a split reciprocal multiply, and the output register.
// Depends on nas_pkg.
module nas_back import nas_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  item_t                    head_i,
  input  logic                     head_valid_i,
  output logic                     pop_o,
  output logic signed [DATA_W-1:0] average_o,
  output logic                     last_o,
  output logic                     average_valid_o,
  input  logic                     average_stall_i
);

  logic [2*DATA_W-1:0] line_mem [LINE_DEPTH];

  logic                adv;

  // gather stage
  logic                s1_valid_q;
  item_t               s1_item_q;
  logic [2*DATA_W-1:0] rdata_q;
  logic [2*DATA_W-1:0] entry_q;
  logic [DATA_W-1:0]   left_q;
  logic [SUM_W-1:0]    sum;

  // bias and shift stage
  logic                s2_valid_q;
  logic [SUM_W-1:0]    s2_sum_q;
  div_e                s2_div_q;
  logic                s2_last_q;
  logic [SUM_W-1:0]    biased;
  logic [SUM_W-1:0]    shr1;
  logic [SUM_W-1:0]    shr2;

  // partial product stage
  logic                s3_valid_q;
  logic [SUM_W-1:0]    s3_u_q;
  logic [DATA_W-1:0]   s3_alt_q;
  div_e                s3_div_q;
  logic                s3_last_q;
  logic [32:0]         pp_hh_q;
  logic [33:0]         pp_hl_q;
  logic [34:0]         pp_lh_q;
  logic [35:0]         pp_ll_q;
  logic [DATA_W-1:0]   alt_q;
  div_e                div_q;
  logic                last_q;
  logic                pp_valid_q;
  logic [35:0]         pp_mid;
  logic [68:0]         product;
  logic [DATA_W-1:0]   quot3;

  // output register
  logic                out_valid_q;
  logic [DATA_W-1:0]   average_q;
  logic                out_last_q;

  assign adv   = !out_valid_q || !average_stall_i;
  assign pop_o = adv && head_valid_i;

  // line store: capture the next column on pop, write back the rotated entry
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= line_mem[head_i.rd_addr];
    end
    if (adv && s1_valid_q) begin
      line_mem[s1_item_q.wr_addr] <= {entry_q[DATA_W-1:0], s1_item_q.sample};
    end
  end

  always_comb begin
    sum = '0;
    if (s1_item_q.use_up) begin
      sum = sum + {{2{entry_q[2*DATA_W-1]}}, entry_q[2*DATA_W-1:DATA_W]};
    end
    if (s1_item_q.use_down) begin
      sum = sum + {{2{s1_item_q.sample[DATA_W-1]}}, s1_item_q.sample};
    end
    if (s1_item_q.use_left) begin
      sum = sum + {{2{left_q[DATA_W-1]}}, left_q};
    end
    if (s1_item_q.use_right) begin
      sum = sum + {{2{rdata_q[DATA_W-1]}}, rdata_q[DATA_W-1:0]};
    end
  end

  always_comb begin
    biased = s2_sum_q + OFFSET3;
    shr1   = {s2_sum_q[SUM_W-1], s2_sum_q[SUM_W-1:1]};
    shr2   = {{2{s2_sum_q[SUM_W-1]}}, s2_sum_q[SUM_W-1:2]};
  end

  always_comb begin
    pp_mid  = {2'b00, pp_hl_q} + {1'b0, pp_lh_q};
    product = {pp_hh_q, 36'd0} + {15'd0, pp_mid, 18'd0} + {33'd0, pp_ll_q};
    // undo the bias: subtracting 2^31 flips the top bit
    quot3   = {~product[67], product[66:36]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_o) begin
        s1_item_q <= head_i;
      end
      if (s1_valid_q) begin
        entry_q <= rdata_q;
        left_q  <= entry_q[DATA_W-1:0];
      end
      s2_sum_q  <= sum;
      s2_div_q  <= s1_item_q.div;
      s2_last_q <= s1_item_q.last;

      s3_u_q    <= biased;
      s3_alt_q  <= (s2_div_q == DIV_BY_4) ? shr2[DATA_W-1:0] : shr1[DATA_W-1:0];
      s3_div_q  <= s2_div_q;
      s3_last_q <= s2_last_q;

      pp_hh_q <= s3_u_q[33:18] * RECIP3_HI;
      pp_hl_q <= s3_u_q[33:18] * RECIP3_LO;
      pp_lh_q <= s3_u_q[17:0] * RECIP3_HI;
      pp_ll_q <= s3_u_q[17:0] * RECIP3_LO;
      alt_q   <= s3_alt_q;
      div_q   <= s3_div_q;
      last_q  <= s3_last_q;

      average_q  <= (div_q == DIV_BY_3) ? quot3 : alt_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      pp_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o;
      // drop halo beats here; they only update the line store
      s2_valid_q  <= s1_valid_q && s1_item_q.produce;
      s3_valid_q  <= s2_valid_q;
      pp_valid_q  <= s3_valid_q;
      out_valid_q <= pp_valid_q;
    end
  end

  assign average_o       = average_q;
  assign last_o          = out_last_q;
  assign average_valid_o = out_valid_q;

endmodule

// ===== tb/tb_neighbor_average_stencil_core.sv =====
// Self-checking bench for neighbor_average_stencil_core: streams haloed tiles,
// mirrors the stencil per accepted beat and compares every result beat in order.
// Depends on nas_pkg and the core RTL only.
module tb_neighbor_average_stencil_core;
  import nas_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 300;
  localparam int RAND_ITEMS     = 450;
  localparam int QUIET_FROM     = 350;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic                     last;
  } cell_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [TILE_W-1:0]        cfg_data_i = '0;
  logic signed [DATA_W-1:0] sample_i = '0;
  logic                     sample_valid_i = 1'b0;
  logic                     sample_stall_o;
  logic signed [DATA_W-1:0] average_o;
  logic                     last_o;
  logic                     average_valid_o;
  logic                     average_stall_i = 1'b0;

  neighbor_average_stencil_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .sample_valid_i  (sample_valid_i),
    .sample_stall_o  (sample_stall_o),
    .average_o       (average_o),
    .last_o          (last_o),
    .average_valid_o (average_valid_o),
    .average_stall_i (average_stall_i)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the core: registers, line store, left neighbor and position.
  logic [TILE_W-1:0]   tile_reg = TILE_RESET;
  logic                up_en = 1'b0;
  logic                down_en = 1'b0;
  logic                left_en = 1'b0;
  logic                right_en = 1'b0;
  logic [2*DATA_W-1:0] mirror_lines [LINE_DEPTH];
  logic [DATA_W-1:0]   mirror_left = '0;
  int unsigned         mirror_row = 0;
  int unsigned         mirror_col = 0;

  logic signed [DATA_W-1:0] sample_pending [$];
  cell_result_t             avg_due_q [$];

  bit          sample_beat = 1'b0;
  bit          noise_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned idle_run = 0;
  int unsigned mismatches = 0;
  int unsigned samples_in = 0;
  int unsigned cells_checked = 0;
  int unsigned tile_ends = 0;
  int unsigned cfg_writes = 0;

  logic signed [DATA_W-1:0] opening_tile [16] = '{
    S_MAX, S_MIN, S_MAX, S_MIN,
    S_MIN, -32'sd1, 32'sd1, S_MAX,
    S_MAX, S_MIN, -32'sd1, S_MIN,
    32'sd0, -32'sd3, S_MIN, S_MAX
  };

  function automatic int unsigned tile_eff();
    if (tile_reg < 2) return 2;
    if (tile_reg > MAX_TILE) return MAX_TILE;
    return tile_reg;
  endfunction

  // Advance the mirror by one sample; return 1 when a cell result falls out.
  function automatic bit stencil_step(input logic signed [DATA_W-1:0] smp,
                                      output cell_result_t res);
    int unsigned t, w, pr, pc;
    logic [2*DATA_W-1:0] entry;
    logic signed [DATA_W-1:0] up_v, left_v, right_v;
    longint sum, cnt, q;
    bit got;
    t = tile_eff();
    w = t + 2;
    pr = mirror_row;
    pc = mirror_col;
    if (pr >= w || pc >= w) begin
      pr = 0;
      pc = 0;
    end
    entry = mirror_lines[pc];
    res = '0;
    got = 1'b0;
    if (pr >= 2 && pc >= 1 && pc <= t) begin
      up_v = entry[2*DATA_W-1:DATA_W];
      left_v = mirror_left;
      right_v = mirror_lines[pc+1][DATA_W-1:0];
      sum = 0;
      cnt = 0;
      if (pr - 1 > 1 || up_en) begin
        sum += up_v;
        cnt++;
      end
      if (pr - 1 < t || down_en) begin
        sum += smp;
        cnt++;
      end
      if (pc > 1 || left_en) begin
        sum += left_v;
        cnt++;
      end
      if (pc < t || right_en) begin
        sum += right_v;
        cnt++;
      end
      q = sum / cnt;
      // floor, not truncate
      if ((sum % cnt) != 0 && sum < 0) q -= 1;
      res.average = q[DATA_W-1:0];
      res.last = (pr - 1 == t) && (pc == t);
      got = 1'b1;
    end
    mirror_lines[pc] = {entry[DATA_W-1:0], smp};
    mirror_left = entry[DATA_W-1:0];
    pc++;
    if (pc >= w) begin
      pc = 0;
      pr++;
      if (pr >= w) pr = 0;
    end
    mirror_row = pr;
    mirror_col = pc;
    return got;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return DATA_W'(int'($urandom_range(0, 16)) - 8);
      3: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Write one register while the core is idle and update the mirror to match.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TILE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_TILE_SIZE: begin
        tile_reg = val;
        mirror_row = 0;
        mirror_col = 0;
      end
      CFG_HAS_UP:    up_en = val[0];
      CFG_HAS_DOWN:  down_en = val[0];
      CFG_HAS_LEFT:  left_en = val[0];
      CFG_HAS_RIGHT: right_en = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_samples(input int unsigned n);
    repeat (n) sample_pending.push_back(pick_sample());
  endtask

  // Hold off until every beat is in and every result out, then let the pipe empty.
  task automatic settle();
    while (sample_pending.size() != 0 || sample_valid_i || avg_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: hold a stalled beat, otherwise idle in bursts or send the next sample.
  always @(negedge clk_i) begin : drive_samples
    if (sample_valid_i && !sample_beat) begin
      // hold
    end else if (src_gap != 0) begin
      src_gap--;
      sample_valid_i <= 1'b0;
    end else if (noise_on && $urandom_range(0, 11) == 0) begin
      src_gap = $urandom_range(0, 13);
      sample_valid_i <= 1'b0;
    end else if (sample_pending.size() != 0) begin
      sample_i <= sample_pending.pop_front();
      sample_valid_i <= 1'b1;
    end else begin
      sample_valid_i <= 1'b0;
    end
  end

  // Receiver: long hold-offs on request, short stall bursts otherwise.
  always @(negedge clk_i) begin : drive_stall
    if (hold_served != hold_requests) begin
      hold_served++;
      sink_hold = LONG_HOLD;
    end
    if (sink_hold != 0) begin
      sink_hold--;
      average_stall_i <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      average_stall_i <= 1'b1;
    end else if (noise_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 13);
      average_stall_i <= 1'b1;
    end else begin
      average_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_beats
    cell_result_t fresh, due;
    bit in_beat, out_beat;
    if (rst_ni) begin
      in_beat = sample_valid_i && !sample_stall_o;
      out_beat = average_valid_o && !average_stall_i;
      sample_beat <= in_beat;
      if (in_beat) begin
        samples_in++;
        if (stencil_step(sample_i, fresh)) avg_due_q.push_back(fresh);
      end
      if (out_beat) begin
        if (avg_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: average %h last %b", average_o, last_o);
        end else begin
          due = avg_due_q.pop_front();
          cells_checked++;
          if (due.last) tile_ends++;
          if (average_o !== due.average || last_o !== due.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cell %0d: expected average %h last %b, got average %h last %b",
                       cells_checked, due.average, due.last, average_o, last_o);
          end
        end
      end
      if (in_beat || out_beat) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("neighbor_average_stencil_core: mismatch");
        $finish;
      end
    end
  end

  initial begin : run_phases
    int unsigned tsz, n, w, rand_items, phase;
    foreach (mirror_lines[i]) mirror_lines[i] = '0;
    rand_items = 0;
    phase = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Undersized tile acts as 2; flags chosen so the four cells divide by 4, 3, 3 and 2.
    // Only bit 0 of a flag write counts; spare indexes are ignored.
    cfg_write(CFG_TILE_SIZE, 9'd1);
    cfg_write(CFG_HAS_UP, 9'd1);
    cfg_write(CFG_HAS_DOWN, 9'h1FE);
    cfg_write(CFG_HAS_LEFT, 9'h1FF);
    cfg_write(CFG_HAS_RIGHT, 9'd0);
    cfg_write(CFG_SPARE_LO, 9'h1FF);
    cfg_write(CFG_SPARE_LO + 3'd1, 9'h0AA);
    cfg_write(CFG_SPARE_LO + 3'd2, 9'h155);
    foreach (opening_tile[i]) sample_pending.push_back(opening_tile[i]);
    settle();

    // Largest tile, a few rows only; once results flow the receiver holds off
    // long enough to fill the core.
    cfg_write(CFG_TILE_SIZE, TILE_RESET);
    cfg_write(CFG_HAS_UP, TILE_W'($urandom));
    cfg_write(CFG_HAS_LEFT, TILE_W'($urandom));
    cfg_write(CFG_HAS_RIGHT, TILE_W'($urandom));
    queue_samples(3 * LINE_DEPTH + 10);
    while (avg_due_q.size() == 0) @(posedge clk_i);
    hold_requests++;
    settle();
    // Oversized tile acts as the largest.
    cfg_write(CFG_TILE_SIZE, 9'h1FF);
    queue_samples(2 * LINE_DEPTH + 40);
    settle();

    while (rand_items < RAND_ITEMS) begin
      if (rand_items >= QUIET_FROM) noise_on = 1'b0;
      // Either restart with a new size or carry on mid-tile with new flags.
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: tsz = $urandom_range(0, 1);
          1: tsz = $urandom_range(9, 24);
          default: tsz = $urandom_range(2, 8);
        endcase
        if (phase == 0) tsz = 0;
        cfg_write(CFG_TILE_SIZE, tsz[TILE_W-1:0]);
      end
      if ($urandom_range(0, 1)) cfg_write(CFG_HAS_UP, TILE_W'($urandom));
      if ($urandom_range(0, 1)) cfg_write(CFG_HAS_DOWN, TILE_W'($urandom));
      if ($urandom_range(0, 1)) cfg_write(CFG_HAS_LEFT, TILE_W'($urandom));
      if ($urandom_range(0, 1)) cfg_write(CFG_HAS_RIGHT, TILE_W'($urandom));
      if ($urandom_range(0, 7) == 0)
        cfg_write(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), TILE_W'($urandom));
      if (phase == 3) hold_requests++;
      w = tile_eff() + 2;
      n = (w > 10) ? $urandom_range(1, w * w) : $urandom_range(1, 3 * w * w);
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      queue_samples(n);
      rand_items += n;
      settle();
      phase++;
    end

    $display("covered %0d samples, %0d cells checked over %0d complete tiles, %0d register writes",
             samples_in, cells_checked, tile_ends, cfg_writes);
    if (mismatches == 0 && avg_due_q.size() == 0) begin
      $display("neighbor_average_stencil_core: match");
    end else begin
      $display("neighbor_average_stencil_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nas_pkg.sv
rtl/nas_front.sv
rtl/nas_queue.sv
rtl/nas_back.sv
rtl/neighbor_average_stencil_core.sv
tb/tb_neighbor_average_stencil_core.sv
